@@ hw/rtl/hslp_pkg.sv @@
// Shared types and constants for the linear-probing hash set insert block.
`timescale 1ns / 1ps

package hslp_pkg;

   localparam int KEY_W     = 64;
   localparam int SLOT_W    = 12;
   localparam int OUTCOME_W = 2;

   // Hash multipliers.
   localparam logic [KEY_W-1:0] HASH_MUL_A = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [KEY_W-1:0] HASH_MUL_B = 64'hC2B2_AE3D_27D4_EB4F;

   // Outcome codes.
   localparam logic [OUTCOME_W-1:0] OUTCOME_INSERTED = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_PRESENT  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_FULL     = 2'd2;

   // One table slot as stored in the slot memory.
   typedef struct packed {
      logic             used;
      logic [KEY_W-1:0] key_upper;
      logic [KEY_W-1:0] key_low;
   } slot_entry_type;

endpackage

@@ hw/rtl/hash_set_linear_probe_insert.sv @@
// Top level of the linear-probing hash set insert block.
// The hash runs on one shared 32x32 multiplier; each probe is one read and one check.
// Throughput: one transaction at a time; the next is accepted once the previous result is staged.
// Reset: synchronous; a clearing pass over every slot then empties the slot memory,
// and req_stall stays high until it is done.
`timescale 1ns / 1ps

module hash_set_linear_probe_insert #(
   parameter int INDEX_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [hslp_pkg::KEY_W-1:0]      req_key_low,
   input  logic [hslp_pkg::KEY_W-1:0]      req_key_upper,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [hslp_pkg::OUTCOME_W-1:0]  rsp_outcome,
   output logic [hslp_pkg::SLOT_W-1:0]     rsp_slot_index
);
   import hslp_pkg::*;

   localparam int TABLE_SIZE = 1 << INDEX_BITS;

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;
   localparam logic [2:0] ST_HOLD  = 3'd5;

   // Multiply step codes.
   localparam logic [1:0] STEP_LL = 2'd0;
   localparam logic [1:0] STEP_LH = 2'd1;
   localparam logic [1:0] STEP_HL = 2'd2;

   logic [2:0]            state_ff, state_in;
   logic [1:0]            step_ff, step_in;
   logic                  phase_ff, phase_in;
   logic [KEY_W-1:0]      op_ff, op_in;
   logic [KEY_W-1:0]      acc_ff, acc_in;
   logic [KEY_W-1:0]      key_low_ff, key_low_in;
   logic [KEY_W-1:0]      key_upper_ff, key_upper_in;
   logic [INDEX_BITS-1:0] pos_ff, pos_in;
   logic [INDEX_BITS-1:0] probe_cnt_ff, probe_cnt_in;
   logic [OUTCOME_W-1:0]  res_outcome_ff, res_outcome_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUTCOME_W-1:0]  rsp_outcome_ff, rsp_outcome_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;

   slot_entry_type        slot_mem [TABLE_SIZE];
   slot_entry_type        rd_entry_ff;
   slot_entry_type        wr_entry;
   logic                  wr_en;

   logic [KEY_W-1:0]      mul_const;
   logic [31:0]           mul_a;
   logic [31:0]           mul_b;
   logic [KEY_W-1:0]      mul_p;
   logic                  req_take;
   logic                  rsp_free;
   logic                  key_match;

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Shared 32x32 multiplier: one partial product of a 64-bit multiply per cycle.
   always_comb begin
      mul_const = phase_ff ? HASH_MUL_B : HASH_MUL_A;
      mul_a = (step_ff == STEP_HL) ? op_ff[63:32] : op_ff[31:0];
      mul_b = (step_ff == STEP_LH) ? mul_const[63:32] : mul_const[31:0];
      mul_p = 64'(mul_a) * 64'(mul_b);
      if (step_ff == STEP_LL) begin
         acc_in = mul_p;
      end else begin
         acc_in = acc_ff + {mul_p[31:0], 32'h0000_0000};
      end
   end

   assign key_match = (rd_entry_ff.key_low == key_low_ff) &&
                      (rd_entry_ff.key_upper == key_upper_ff);

   // Sequencer and result staging.
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      phase_in       = phase_ff;
      op_in          = op_ff;
      key_low_in     = key_low_ff;
      key_upper_in   = key_upper_ff;
      pos_in         = pos_ff;
      probe_cnt_in   = probe_cnt_ff;
      res_outcome_in = res_outcome_ff;
      res_slot_in    = res_slot_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_slot_in    = rsp_slot_ff;
      wr_en          = 1'b0;
      wr_entry       = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            pos_in = pos_ff + 1'b1;
            if (pos_ff == {INDEX_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               key_low_in   = req_key_low;
               key_upper_in = req_key_upper;
               op_in        = req_key_upper;
               step_in      = STEP_LL;
               phase_in     = 1'b0;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            if (step_ff == STEP_HL) begin
               step_in = STEP_LL;
               if (!phase_ff) begin
                  op_in    = key_low_ff ^ acc_in;
                  phase_in = 1'b1;
               end else begin
                  pos_in       = acc_in[KEY_W-1 -: INDEX_BITS];
                  probe_cnt_in = '0;
                  state_in     = ST_READ;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // Decide this probe: empty slot, matching key, last slot of a full lap, or move on.
            res_slot_in = SLOT_W'(pos_ff);
            if (!rd_entry_ff.used) begin
               wr_en              = 1'b1;
               wr_entry.used      = 1'b1;
               wr_entry.key_low   = key_low_ff;
               wr_entry.key_upper = key_upper_ff;
               res_outcome_in     = OUTCOME_INSERTED;
            end else if (key_match) begin
               res_outcome_in = OUTCOME_PRESENT;
            end else if (probe_cnt_ff == {INDEX_BITS{1'b1}}) begin
               res_outcome_in = OUTCOME_FULL;
               res_slot_in    = '0;
            end
            if (!rd_entry_ff.used || key_match || probe_cnt_ff == {INDEX_BITS{1'b1}}) begin
               if (rsp_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_outcome_in = res_outcome_in;
                  rsp_slot_in    = res_slot_in;
                  state_in       = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end else begin
               pos_in       = pos_ff + 1'b1;
               probe_cnt_in = probe_cnt_ff + 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = res_outcome_ff;
               rsp_slot_in    = res_slot_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pos_ff       <= '0;
         step_ff      <= STEP_LL;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      acc_ff         <= acc_in;
      key_low_ff     <= key_low_in;
      key_upper_ff   <= key_upper_in;
      probe_cnt_ff   <= probe_cnt_in;
      res_outcome_ff <= res_outcome_in;
      res_slot_ff    <= res_slot_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   // Slot memory: one write port, one registered read at the probe position.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[pos_ff] <= wr_entry;
      end
      rd_entry_ff <= slot_mem[pos_ff];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_outcome    = rsp_outcome_ff;
   assign rsp_slot_index = rsp_slot_ff;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the linear-probing hash set insert block.
`timescale 1ns / 1ps

module tb;
   import hslp_pkg::*;

   localparam int IDX_W = 12;
   localparam int TABLE_SLOTS = 1 << IDX_W;
   localparam int RANDOM_ITEMS = 1550;
   localparam int LONG_IDLE = 40;
   localparam int REPORT_MAX = 10;

   typedef struct {
      logic [KEY_W-1:0] lo;
      logic [KEY_W-1:0] hi;
   } key_pair_type;

   typedef struct {
      logic [OUTCOME_W-1:0] outcome;
      logic [SLOT_W-1:0]    slot_index;
      logic [KEY_W-1:0]     lo;
      logic [KEY_W-1:0]     hi;
   } insert_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic [KEY_W-1:0] req_key_low = '0;
   logic [KEY_W-1:0] req_key_upper = '0;
   logic             req_stall;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [OUTCOME_W-1:0] rsp_outcome;
   logic [SLOT_W-1:0]    rsp_slot_index;

   // Shadow copy of the table contents.
   bit               slot_taken [TABLE_SLOTS];
   logic [KEY_W-1:0] slot_lo [TABLE_SLOTS];
   logic [KEY_W-1:0] slot_hi [TABLE_SLOTS];
   int               occupied = 0;

   insert_result_type pending_results [$];
   key_pair_type      known_keys [$];
   int                mismatches = 0;
   bit                calm = 1'b0;
   longint            cycle_count = 0;
   longint            cycle_limit = 4 * TABLE_SLOTS + 5000;

   hash_set_linear_probe_insert #(
      .INDEX_BITS(IDX_W)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_key_low(req_key_low),
      .req_key_upper(req_key_upper),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_outcome(rsp_outcome),
      .rsp_slot_index(rsp_slot_index)
   );

   always #4 clock = ~clock;

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, LONG_IDLE);
   endfunction

   // Start slot: top index bits of the mixed 128-bit key.
   function automatic int home_slot(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi);
      logic [KEY_W-1:0] mixed;
      mixed = (lo ^ (hi * HASH_MUL_A)) * HASH_MUL_B;
      return int'(mixed[KEY_W-1 -: IDX_W]);
   endfunction

   // Builds a low half so that the key lands on the given start slot. The second
   // multiplier is odd, so it has an inverse mod 2^64 (Newton iteration).
   function automatic logic [KEY_W-1:0] key_for_home(input int slot, input logic [KEY_W-1:0] hi);
      logic [KEY_W-1:0] inv;
      logic [KEY_W-1:0] mixed;
      inv = HASH_MUL_B;
      repeat (6) inv = inv * (64'd2 - HASH_MUL_B * inv);
      mixed = {$urandom, $urandom};
      mixed[KEY_W-1 -: IDX_W] = slot[IDX_W-1:0];
      return (mixed * inv) ^ (hi * HASH_MUL_A);
   endfunction

   // A key half biased toward all zeros and all ones.
   function automatic logic [KEY_W-1:0] random_half();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return '0;
      if (r < 24) return '1;
      return {$urandom, $urandom};
   endfunction

   // Probe the shadow table and insert the key when absent.
   task automatic predict_insert(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi,
                                 output logic [OUTCOME_W-1:0] outcome,
                                 output logic [SLOT_W-1:0] slot, output int probes);
      int pos;
      bit done;
      pos = home_slot(lo, hi);
      done = 1'b0;
      outcome = OUTCOME_FULL;
      slot = '0;
      probes = 0;
      for (int n = 0; n < TABLE_SLOTS && !done; n++) begin
         probes = n + 1;
         if (!slot_taken[pos]) begin
            slot_taken[pos] = 1'b1;
            slot_lo[pos] = lo;
            slot_hi[pos] = hi;
            occupied++;
            outcome = OUTCOME_INSERTED;
            slot = pos[SLOT_W-1:0];
            done = 1'b1;
         end else if (slot_lo[pos] == lo && slot_hi[pos] == hi) begin
            outcome = OUTCOME_PRESENT;
            slot = pos[SLOT_W-1:0];
            done = 1'b1;
         end else begin
            pos = (pos + 1) % TABLE_SLOTS;
         end
      end
   endtask

   // Send one key and record what the table should answer for it.
   task automatic send_key(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi);
      int gap;
      int probes;
      insert_result_type want;
      key_pair_type kp;
      gap = calm ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_key_low <= lo;
      req_key_upper <= hi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_insert(lo, hi, want.outcome, want.slot_index, probes);
      want.lo = lo;
      want.hi = hi;
      pending_results.push_back(want);
      if (want.outcome == OUTCOME_INSERTED) begin
         kp.lo = lo;
         kp.hi = hi;
         known_keys.push_back(kp);
      end
      cycle_limit += 4 * (10 + 2 * probes + 2 * LONG_IDLE + 16);
   endtask

   task automatic send_known_key();
      key_pair_type kp;
      kp = known_keys[$urandom_range(0, known_keys.size() - 1)];
      send_key(kp.lo, kp.hi);
   endtask

   // Extreme keys, repeats, and a collision chain that wraps past the last slot.
   task automatic test_directed();
      logic [KEY_W-1:0] hi;
      key_pair_type chain [3];
      send_key('0, '0);
      send_key('0, '0);
      send_key('1, '1);
      send_key('1, '1);
      send_key('1, '0);
      send_key('0, '1);
      send_key(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
      send_key(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      // Three keys on the last slot; slot zero already holds the all-zero key.
      for (int i = 0; i < 3; i++) begin
         hi = {$urandom, $urandom};
         chain[i].lo = key_for_home(TABLE_SLOTS - 1, hi);
         chain[i].hi = hi;
         send_key(chain[i].lo, chain[i].hi);
      end
      for (int i = 2; i >= 0; i--) send_key(chain[i].lo, chain[i].hi);
      // Same low half, high half differs in one bit.
      send_key(64'h0123_4567_89AB_CDEF, 64'h0);
      send_key(64'h0123_4567_89AB_CDEF, 64'h1);
      send_key(64'h0123_4567_89AB_CDEF, 64'h0);
   endtask

   // Fresh keys, repeats of stored keys, and keys aimed at a few crowded slots.
   task automatic test_random();
      int hot [12];
      int pick;
      logic [KEY_W-1:0] hi;
      hot[0] = TABLE_SLOTS - 2;
      hot[1] = TABLE_SLOTS - 1;
      hot[2] = 0;
      hot[3] = TABLE_SLOTS / 2;
      for (int i = 4; i < 12; i++) hot[i] = $urandom_range(0, TABLE_SLOTS - 1);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i % 300) < 50;
         pick = $urandom_range(0, 99);
         if (pick < 35 || known_keys.size() == 0) begin
            send_key(random_half(), random_half());
         end else if (pick < 65) begin
            send_known_key();
         end else begin
            hi = random_half();
            send_key(key_for_home(hot[$urandom_range(0, 11)], hi), hi);
         end
      end
      calm = 1'b0;
   endtask

   // Response stall: alternating runs of stalling and flowing.
   bit stalling = 1'b0;
   int run_left = 0;
   always @(posedge clock) begin
      if (run_left == 0) begin
         stalling = !stalling && !calm;
         run_left = stalling ? idle_length() : $urandom_range(1, 8);
         if (run_left == 0) begin
            stalling = 1'b0;
            run_left = $urandom_range(1, 8);
         end
      end
      run_left--;
      rsp_stall <= stalling;
   end

   // Compare each accepted result transaction with the oldest expectation.
   always @(posedge clock) begin
      insert_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result: outcome %0d slot %0d", rsp_outcome, rsp_slot_index);
         end else begin
            want = pending_results.pop_front();
            if (rsp_outcome !== want.outcome || rsp_slot_index !== want.slot_index) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("mismatch key %h_%h: expected outcome %0d slot %0d, got %0d slot %0d",
                           want.hi, want.lo, want.outcome, want.slot_index,
                           rsp_outcome, rsp_slot_index);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
